/* design/speed_incremental_pi_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for speed_incremental_pi_top
// Shared property forms: same-cycle and next-cycle implications under reset.
// ----------------------------------------------------------------------------
`ifndef SPEED_INCREMENTAL_PI_TOP_DEFINES_SVH
`define SPEED_INCREMENTAL_PI_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SIP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_pkg
// Widths, constants, register indexes and the controller command bundle.
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int TGT_W      = 12;
    localparam int MEAS_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int DRV_W      = 24;
    localparam int CNT_W      = 32;
    localparam int ACC_W      = 32;
    localparam int ACC_FRAC   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int ERR_WIDTH_DEF = 24;

    // error before saturation fits 23 bits signed
    localparam int RAW_W = 24;

    localparam int MEAS_OFS   = 50;
    localparam int MEAS_SCALE = 10;
    localparam int SPEED_BIAS = 1200;
    localparam int I_LIMIT    = 5500;
    localparam int SETTLE_LIM = 10;

    // |err| <= 5500 fits 14 bits signed, ki*|err| fits 30 bits
    localparam int IWIN_W = 14;
    localparam int IMAG_W = GAIN_W + IWIN_W;
    // x/20 = floor(floor(x/4) * 0xCCCCCCCD / 2^34), exact below 2^32
    localparam logic [31:0] RECIP5   = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 34;
    localparam int          Q_W      = 25;

    localparam logic [CFG_IDX_W-1:0] REG_BASIC_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 2'd3;

    localparam logic [GAIN_W-1:0] BASIC_GAIN_RST = 16'd256;
    localparam logic [DRV_W-1:0]  DRIVE_MAX_RST  = 24'h7F_FFFF;

    typedef struct packed {
        logic in_load;
        logic mul_a;
        logic err_calc;
        logic mul_b;
        logic div;
        logic sum;
        logic clamp;
        logic out_load;
    } t_dp_cmd;

endpackage

/* design/sip_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_in_if
// Input channel: valid/ready handshake with one control tick per word.
// ----------------------------------------------------------------------------
interface sip_in_if;
    logic                                valid;
    logic                                ready;
    logic        [sip_pkg::TGT_W-1:0]    target_speed;
    logic signed [sip_pkg::MEAS_W-1:0]   measured_speed;
    logic                                running;

    modport source (
        output valid, target_speed, measured_speed, running,
        input  ready
    );
    modport sink (
        input  valid, target_speed, measured_speed, running,
        output ready
    );
endinterface

/* design/sip_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_out_if
// Output channel: valid/ready handshake carrying drive and settle count.
// ----------------------------------------------------------------------------
interface sip_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sip_pkg::DRV_W-1:0]   drive;
    logic        [sip_pkg::CNT_W-1:0]   settled_count;

    modport source (
        output valid, drive, settled_count,
        input  ready
    );
    modport sink (
        input  valid, drive, settled_count,
        output ready
    );
endinterface

/* design/sip_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_ctrl
// Sequencer that walks one word through the datapath stages.
// ----------------------------------------------------------------------------
module sip_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output sip_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_ERR,
        S_MUL_B,
        S_DIV,
        S_SUM,
        S_CLAMP,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_ERR;
            end
            S_ERR: begin
                o_cmd.err_calc = 1'b1;
                n_state        = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // wait until the previous word has left the output register
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* design/sip_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_dp
// Datapath: config registers, error, PI increments, accumulator, counter.
// ----------------------------------------------------------------------------
module sip_dp #(
    parameter int ERR_WIDTH = sip_pkg::ERR_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sip_pkg::t_dp_cmd                    i_cmd,
    input  logic                                i_cfg_we,
    input  logic [sip_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sip_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [sip_pkg::TGT_W-1:0]           i_target_speed,
    input  logic signed [sip_pkg::MEAS_W-1:0]   i_measured_speed,
    input  logic                                i_running,
    output logic signed [sip_pkg::DRV_W-1:0]    o_drive,
    output logic [sip_pkg::CNT_W-1:0]           o_settled_count
);

    localparam int GW    = sip_pkg::GAIN_W;
    localparam int RW    = sip_pkg::RAW_W;
    localparam int AW    = sip_pkg::ACC_W;
    localparam int PROD_W = sip_pkg::TGT_W + GW;
    localparam int SPD_W = PROD_W - sip_pkg::ACC_FRAC;
    localparam int SAT_W = ((RW > ERR_WIDTH) ? RW : ERR_WIDTH) + 1;
    localparam int PP_W  = ERR_WIDTH + GW + 2;
    localparam int SUM_W = ((PP_W > AW) ? PP_W : AW) + 2;
    localparam int IW    = sip_pkg::IWIN_W;
    localparam int IMW   = sip_pkg::IMAG_W;
    localparam int QW    = sip_pkg::Q_W;
    localparam int QP_W  = IMW - 2 + 32;

    localparam logic signed [RW-1:0] C_OFS   = RW'(sip_pkg::MEAS_OFS);
    localparam logic signed [RW-1:0] C_SCALE = RW'(sip_pkg::MEAS_SCALE);
    localparam logic signed [RW-1:0] C_BIAS  = RW'(sip_pkg::SPEED_BIAS);
    localparam logic signed [SAT_W-1:0] C_EMAX =
        SAT_W'((64'd1 << (ERR_WIDTH - 1)) - 64'd1);
    localparam logic signed [SAT_W-1:0] C_EMIN = -C_EMAX - SAT_W'(1);
    localparam logic signed [ERR_WIDTH-1:0] C_ILIM_P = ERR_WIDTH'(sip_pkg::I_LIMIT);
    localparam logic signed [ERR_WIDTH-1:0] C_ILIM_N = -C_ILIM_P;
    localparam logic signed [ERR_WIDTH-1:0] C_SLIM_P = ERR_WIDTH'(sip_pkg::SETTLE_LIM);
    localparam logic signed [ERR_WIDTH-1:0] C_SLIM_N = -C_SLIM_P;
    localparam logic signed [AW-1:0] C_ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    // configuration
    logic        [GW-1:0]                r_basic_gain;
    logic        [GW-1:0]                r_kp_gain;
    logic        [GW-1:0]                r_ki_gain;
    logic signed [sip_pkg::DRV_W-1:0]    r_drive_max;

    // loop state
    logic signed [ERR_WIDTH-1:0]         r_prev;
    logic signed [AW-1:0]                r_acc;
    logic        [sip_pkg::CNT_W-1:0]    r_cnt;

    // stage registers
    logic        [sip_pkg::TGT_W-1:0]    r_tgt;
    logic signed [sip_pkg::MEAS_W-1:0]   r_meas;
    logic                                r_run;
    logic        [PROD_W-1:0]            r_spd_prod;
    logic signed [RW-1:0]                r_mterm;
    logic signed [ERR_WIDTH-1:0]         r_err;
    logic signed [PP_W-1:0]              r_pprod;
    logic        [IMW-1:0]               r_iprod;
    logic                                r_ineg;
    logic                                r_settle;
    logic signed [QW:0]                  r_iinc;
    logic signed [SUM_W-1:0]             r_sum;
    logic signed [sip_pkg::DRV_W-1:0]    r_o_drive;
    logic        [sip_pkg::CNT_W-1:0]    r_o_cnt;

    logic signed [RW-1:0]                w_raw;
    logic signed [SAT_W-1:0]             w_raw_x;
    logic signed [ERR_WIDTH-1:0]         n_err;
    logic signed [ERR_WIDTH:0]           w_diff;
    logic                                w_iwin;
    logic                                w_swin;
    logic signed [IW-1:0]                w_elow;
    logic        [IW-1:0]                w_emag;
    logic        [QP_W-1:0]              w_qprod;
    logic        [QW-1:0]                w_q;
    logic signed [SUM_W-1:0]             w_cap;
    logic signed [SUM_W-1:0]             w_min;
    logic signed [AW-1:0]                n_acc;

    // error, exact then saturated
    assign w_raw   = $signed({{(RW - SPD_W){1'b0}},
                              r_spd_prod[PROD_W-1:sip_pkg::ACC_FRAC]})
                     - r_mterm - C_BIAS;
    assign w_raw_x = {{(SAT_W - RW){w_raw[RW-1]}}, w_raw};
    always_comb begin
        if (w_raw_x > C_EMAX) begin
            n_err = ERR_WIDTH'(C_EMAX);
        end else if (w_raw_x < C_EMIN) begin
            n_err = ERR_WIDTH'(C_EMIN);
        end else begin
            n_err = ERR_WIDTH'(w_raw_x);
        end
    end

    assign w_diff = {r_err[ERR_WIDTH-1], r_err} - {r_prev[ERR_WIDTH-1], r_prev};
    assign w_iwin = r_run && (r_err <= C_ILIM_P) && (r_err >= C_ILIM_N);
    assign w_swin = r_run && (r_err <= C_SLIM_P) && (r_err >= C_SLIM_N);
    assign w_elow = r_err[IW-1:0];
    assign w_emag = w_elow[IW-1] ? IW'(-w_elow) : IW'(w_elow);

    // divide by twenty: drop two bits, then reciprocal of five
    assign w_qprod = r_iprod[IMW-1:2] * sip_pkg::RECIP5;
    assign w_q     = w_qprod[sip_pkg::RECIP_SH+QW-1:sip_pkg::RECIP_SH];

    assign w_cap = SUM_W'($signed({r_drive_max, {sip_pkg::ACC_FRAC{1'b0}}}));
    assign w_min = SUM_W'(C_ACC_MIN);
    always_comb begin
        if (r_sum >= w_cap) begin
            n_acc = AW'(w_cap);
        end else if (r_sum < w_min) begin
            n_acc = C_ACC_MIN;
        end else begin
            n_acc = AW'(r_sum);
        end
    end

    // config and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basic_gain <= sip_pkg::BASIC_GAIN_RST;
            r_kp_gain    <= '0;
            r_ki_gain    <= '0;
            r_drive_max  <= sip_pkg::DRIVE_MAX_RST;
            r_prev       <= '0;
            r_acc        <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sip_pkg::REG_BASIC_GAIN: r_basic_gain <= i_cfg_wdata[GW-1:0];
                    sip_pkg::REG_KP_GAIN:    r_kp_gain    <= i_cfg_wdata[GW-1:0];
                    sip_pkg::REG_KI_GAIN:    r_ki_gain    <= i_cfg_wdata[GW-1:0];
                    sip_pkg::REG_DRIVE_MAX:  r_drive_max  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.clamp) begin
                r_acc  <= n_acc;
                r_prev <= r_err;
                if (r_settle) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_tgt  <= i_target_speed;
            r_meas <= i_measured_speed;
            r_run  <= i_running;
        end
        if (i_cmd.mul_a) begin
            r_spd_prod <= r_tgt * r_basic_gain;
            r_mterm    <= (RW'(r_meas) - C_OFS) * C_SCALE;
        end
        if (i_cmd.err_calc) begin
            r_err <= n_err;
        end
        if (i_cmd.mul_b) begin
            r_pprod  <= $signed({1'b0, r_kp_gain}) * w_diff;
            r_iprod  <= w_iwin ? (r_ki_gain * w_emag) : '0;
            r_ineg   <= r_err[ERR_WIDTH-1];
            r_settle <= w_swin;
        end
        if (i_cmd.div) begin
            r_iinc <= r_ineg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
        end
        if (i_cmd.sum) begin
            r_sum <= SUM_W'(r_acc) + SUM_W'(r_pprod >>> 1) + SUM_W'(r_iinc);
        end
        if (i_cmd.out_load) begin
            r_o_drive <= r_acc[AW-1:sip_pkg::ACC_FRAC];
            r_o_cnt   <= r_cnt;
        end
    end

    assign o_drive         = r_o_drive;
    assign o_settled_count = r_o_cnt;

endmodule

/* design/speed_incremental_pi_top.sv */
`timescale 1ns / 1ps
`include "speed_incremental_pi_top_defines.svh"
// ----------------------------------------------------------------------------
// speed_incremental_pi_top
// Incremental PI speed controller with integral separation, one word/tick.
// ----------------------------------------------------------------------------
// Each input word (target speed, measured speed, running flag) produces one
// output word: the integer part of the drive accumulator after the update and
// the settle count. From acceptance to the next ready, the controller steps
// the word through the datapath one stage per cycle while the output register
// can take it (capture, gain multiply, error saturation, PI multiplies,
// reciprocal divide by twenty, accumulate, clamp, output load). Only one word
// is in flight; ready is high while the sequencer is idle. The result sits in
// an output register, so a new word is accepted while the last result is
// still unread; the final stage waits only if that register is still full.
// Configuration writes land directly in the datapath registers and should be
// issued while idle. No clearing pass after reset.
// ----------------------------------------------------------------------------
module speed_incremental_pi_top #(
    // error width: sets saturation range and the previous-error register
    parameter int ERR_WIDTH = sip_pkg::ERR_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sip_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sip_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    sip_in_if.sink                            i_in,
    sip_out_if.source                         o_out
);

    sip_pkg::t_dp_cmd w_cmd;
    logic             w_in_ready;
    logic             w_out_valid;

    // sequencer: one state per datapath stage
    sip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // arithmetic, loop state and the output word register
    sip_dp #(
        .ERR_WIDTH (ERR_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_target_speed   (i_in.target_speed),
        .i_measured_speed (i_in.measured_speed),
        .i_running        (i_in.running),
        .o_drive          (o_out.drive),
        .o_settled_count  (o_out.settled_count)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // one word in flight: ready drops right after an accept
    `SIP_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "second word accepted while busy")
    // an accepted word always starts the datapath
    `SIP_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_cmd.in_load, w_cmd.mul_a, "accepted word did not enter the datapath")
    // a new result never overwrites an unread one
    `SIP_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !o_out.valid || o_out.ready, "output word overwritten before it was taken")

endmodule
